FILE: sv/lzss_window_compressor_assert.svh
// ----------------------------------------------------------------------------
// LZSS compressor assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_COMPRESSOR_ASSERT_SVH
`define LZSS_WINDOW_COMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LZSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LZSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LZSS_ASSERT(lbl, prop, msg)
`define LZSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/lzss_pkg.sv
// ----------------------------------------------------------------------------
// LZSS compressor package
// Fixed token format constants and the match cell control type.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MIN_MATCH = 3;
  localparam int unsigned LEN_SHIFT = 12;
  localparam int unsigned GROUP_LEN = 8;
  localparam int unsigned GROUP_BUF = 16;

  typedef struct packed {
    logic shift_hist;
    logic shift_look;
  } cell_ctrl_t;

endpackage

FILE: sv/lzss_if.sv
// ----------------------------------------------------------------------------
// LZSS stream interfaces
// Valid/ready channels for raw input bytes and compressed output bytes.
// ----------------------------------------------------------------------------
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in;

  modport source (output valid, output data_byte, output last_in, input ready);
  modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: sv/lzss_window_compressor.sv
// ----------------------------------------------------------------------------
// LZSS window compressor
// Raw bytes in on in_i (last_in on the final byte), LZSS byte stream out on
// out_o: a flag byte, then up to eight tokens of one literal or two code bytes.
//
// Bytes are stored in a ring RAM of WINDOW_SIZE+MAX_MATCH entries. Once
// MAX_MATCH bytes of lookahead are held (or at the end of the stream) a
// token is encoded: the lookahead is loaded into a row of MAX_MATCH cells,
// then the window streams through the row one RAM read per cycle, each
// position giving one candidate distance (at most WINDOW_SIZE-1 positions,
// the bytes seen). The token rate is set by the single RAM read port.
// A completed group goes out one byte per cycle while the sink is ready
// (9 to 17 beats, fewer for a short final group); the output register lets
// an input beat be taken while a result waits. While the sink stalls the
// flush holds and no input is taken. The final beat of a stream carries
// out_last, and the block then starts a fresh stream.
// Reset clears all control state; RAM contents need no clearing.
// ----------------------------------------------------------------------------
`include "lzss_window_compressor_assert.svh"

module lzss_window_compressor import lzss_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 4096,
  parameter int unsigned MAX_MATCH   = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzss_in_if.sink    in_i,
  lzss_out_if.source out_o
);

  localparam int unsigned RING_LEN = WINDOW_SIZE + MAX_MATCH;
  localparam int unsigned AW  = $clog2(RING_LEN);
  localparam int unsigned SW  = $clog2(WINDOW_SIZE);
  localparam int unsigned FW  = $clog2(MAX_MATCH + 1);
  localparam int unsigned DW  = $clog2(WINDOW_SIZE + MAX_MATCH + 1);
  localparam int unsigned GW  = $clog2(GROUP_BUF + 1);
  localparam int unsigned GIW = $clog2(GROUP_BUF);
  localparam int unsigned TW  = $clog2(GROUP_LEN + 1);
  localparam int unsigned KW  = $clog2(GROUP_LEN);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     wh_q, wh_d;
  logic [SW-1:0]     seen_q, seen_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic              end_q, end_d;
  logic [GW-1:0]     gfill_q, gfill_d;
  logic [TW-1:0]     tok_q, tok_d;
  logic [7:0]        flags_q, flags_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [FW-1:0]     lim_q, lim_d;
  logic [SW-1:0]     dmax_q, dmax_d;
  logic [AW-1:0]     raddr_q, raddr_d;
  logic [DW-1:0]     iss_q, iss_d;
  logic              rd_v_q, rd_v_d;
  logic              ev_v_q, ev_v_d;
  logic [DW-1:0]     dcnt_q, dcnt_d;
  logic [FW-1:0]     best_q, best_d;
  logic [SW-1:0]     bestd_q, bestd_d;
  logic [GW-1:0]     fcnt_q, fcnt_d;
  logic              fin_q, fin_d;
  logic              out_v_q, out_v_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [BYTE_W-1:0] gbuf_q [GROUP_BUF];

  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  logic              in_acc;
  logic              flush_load;
  logic              gb_we0, gb_we1;
  logic [GIW-1:0]    gb_idx0, gb_idx1;
  logic [BYTE_W-1:0] gb_dat0, gb_dat1;

  cell_ctrl_t        ctrl;
  logic [BYTE_W-1:0] hist_w [MAX_MATCH+1];
  logic [BYTE_W-1:0] look_w [MAX_MATCH+1];
  logic [MAX_MATCH-1:0] live;
  logic [MAX_MATCH-1:0] run;
  logic [FW-1:0]     cur_len;
  logic [BYTE_W-1:0] look0;

  // ring RAM
  assign in_acc = in_i.valid && in_i.ready;
  assign ram_we = in_acc;

  lzss_ram #(.WIDTH(BYTE_W), .DEPTH(RING_LEN)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wh_q),
    .wdata_i (in_i.data_byte),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  // match row: RAM data enters at the top cell and moves towards cell 0
  assign ctrl.shift_look = rd_v_q && (state_q == S_LOAD);
  assign ctrl.shift_hist = rd_v_q && (state_q == S_SCAN);
  assign hist_w[MAX_MATCH] = ram_rdata;
  assign look_w[MAX_MATCH] = ram_rdata;

  for (genvar c = 0; c < MAX_MATCH; c++) begin : g_cell
    logic run_in;
    assign live[c] = (FW'(c) < lim_q);
    if (c == 0) begin : g_first
      assign run_in = 1'b1;
    end else begin : g_next
      assign run_in = run[c-1];
    end
    lzss_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .hist_i (hist_w[c+1]),
      .look_i (look_w[c+1]),
      .live_i (live[c]),
      .run_i  (run_in),
      .hist_o (hist_w[c]),
      .look_o (look_w[c]),
      .run_o  (run[c])
    );
  end

  assign cur_len = FW'($countones(run));
  assign look0   = look_w[0];
  assign flush_load = (state_q == S_FLUSH) && (!out_v_q || out_o.ready);

  always_comb begin
    logic [AW:0]   wide_a;
    logic [AW:0]   wide_b;
    logic [FW-1:0] used;
    logic [SW:0]   seen_sum;
    logic [3:0]    len_code;
    logic [11:0]   dist12;
    logic [GW-1:0] gidx;

    state_d    = state_q;
    wh_d       = wh_q;
    seen_d     = seen_q;
    fill_d     = fill_q;
    end_d      = end_q;
    gfill_d    = gfill_q;
    tok_d      = tok_q;
    flags_d    = flags_q;
    pos_d      = pos_q;
    lim_d      = lim_q;
    dmax_d     = dmax_q;
    raddr_d    = raddr_q;
    iss_d      = iss_q;
    rd_v_d     = 1'b0;
    ev_v_d     = 1'b0;
    dcnt_d     = dcnt_q;
    best_d     = best_q;
    bestd_d    = bestd_q;
    fcnt_d     = fcnt_q;
    fin_d      = fin_q;
    out_v_d    = out_v_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    gb_we0     = 1'b0;
    gb_we1     = 1'b0;
    gb_idx0    = gfill_q[GIW-1:0];
    gb_idx1    = GIW'(gfill_q + GW'(1));
    gb_dat0    = look0;
    gb_dat1    = look0;
    wide_a     = '0;
    wide_b     = '0;
    used       = '0;
    seen_sum   = '0;
    len_code   = '0;
    dist12     = '0;
    gidx       = '0;

    if (out_v_q && out_o.ready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          wh_d    = (wh_q == AW'(RING_LEN - 1)) ? '0 : wh_q + AW'(1);
          fill_d  = fill_q + FW'(1);
          end_d   = in_i.last_in;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (end_q && (fill_q == '0)) begin
          if (tok_q != '0) begin
            fin_d   = 1'b1;
            fcnt_d  = '0;
            state_d = S_FLUSH;
          end else begin
            wh_d    = '0;
            seen_d  = '0;
            end_d   = 1'b0;
            state_d = S_IDLE;
          end
        end else if (end_q || (fill_q >= FW'(MAX_MATCH))) begin
          wide_a  = {1'b0, wh_q};
          wide_b  = (AW+1)'(fill_q);
          if (wide_a < wide_b) begin
            wide_a = wide_a + (AW+1)'(RING_LEN);
          end
          pos_d   = AW'(wide_a - wide_b);
          raddr_d = AW'(wide_a - wide_b);
          lim_d   = fill_q;
          dmax_d  = seen_q;
          iss_d   = DW'(MAX_MATCH);
          state_d = S_LOAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LOAD, S_SCAN: begin
        if (iss_q != '0) begin
          rd_v_d  = 1'b1;
          iss_d   = iss_q - DW'(1);
          raddr_d = (raddr_q == AW'(RING_LEN - 1)) ? '0 : raddr_q + AW'(1);
        end
        if (state_q == S_LOAD) begin
          if ((iss_q == '0) && !rd_v_q) begin
            best_d  = '0;
            bestd_d = '0;
            if (dmax_q == '0) begin
              state_d = S_EMIT;
            end else begin
              wide_a  = {1'b0, pos_q};
              wide_b  = (AW+1)'(dmax_q);
              if (wide_a < wide_b) begin
                wide_a = wide_a + (AW+1)'(RING_LEN);
              end
              raddr_d = AW'(wide_a - wide_b);
              iss_d   = DW'(dmax_q) + DW'(MAX_MATCH - 1);
              dcnt_d  = DW'(dmax_q) + DW'(MAX_MATCH);
              state_d = S_SCAN;
            end
          end
        end else begin
          if (rd_v_q) begin
            dcnt_d = dcnt_q - DW'(1);
            ev_v_d = 1'b1;
          end
          // distances fall as the window slides, so >= keeps the nearest
          if (ev_v_q && (dcnt_q <= DW'(dmax_q)) && (cur_len >= best_q)) begin
            best_d  = cur_len;
            bestd_d = SW'(dcnt_q);
          end
          if ((iss_q == '0) && !rd_v_q && !ev_v_q) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (best_q < FW'(MIN_MATCH)) begin
          gb_we0  = 1'b1;
          gb_dat0 = look0;
          gfill_d = gfill_q + GW'(1);
          used    = FW'(1);
        end else begin
          len_code = 4'(best_q - FW'(MIN_MATCH));
          dist12   = 12'(bestd_q);
          gb_we0   = 1'b1;
          gb_we1   = 1'b1;
          gb_dat0  = {len_code, dist12[LEN_SHIFT-1:8]};
          gb_dat1  = dist12[7:0];
          flags_d  = flags_q | (8'd1 << tok_q[KW-1:0]);
          gfill_d  = gfill_q + GW'(2);
          used     = best_q;
        end
        fill_d   = fill_q - used;
        seen_sum = (SW+1)'(seen_q) + (SW+1)'(used);
        seen_d   = (seen_sum > (SW+1)'(WINDOW_SIZE - 1)) ? SW'(WINDOW_SIZE - 1)
                                                          : SW'(seen_sum);
        tok_d    = tok_q + TW'(1);
        if (tok_d == TW'(GROUP_LEN)) begin
          fin_d   = end_q && (fill_d == '0);
          fcnt_d  = '0;
          state_d = S_FLUSH;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_FLUSH: begin
        if (flush_load) begin
          gidx       = fcnt_q - GW'(1);
          out_v_d    = 1'b1;
          out_byte_d = (fcnt_q == '0) ? flags_q : gbuf_q[gidx[GIW-1:0]];
          out_last_d = fin_q && (fcnt_q == gfill_q);
          fcnt_d     = fcnt_q + GW'(1);
          if (fcnt_q == gfill_q) begin
            gfill_d = '0;
            tok_d   = '0;
            flags_d = '0;
            fin_d   = 1'b0;
            if (fin_q) begin
              wh_d    = '0;
              seen_d  = '0;
              end_d   = 1'b0;
              state_d = S_IDLE;
            end else begin
              state_d = S_CHECK;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      wh_q       <= '0;
      seen_q     <= '0;
      fill_q     <= '0;
      end_q      <= 1'b0;
      gfill_q    <= '0;
      tok_q      <= '0;
      flags_q    <= '0;
      iss_q      <= '0;
      rd_v_q     <= 1'b0;
      ev_v_q     <= 1'b0;
      fcnt_q     <= '0;
      fin_q      <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wh_q       <= wh_d;
      seen_q     <= seen_d;
      fill_q     <= fill_d;
      end_q      <= end_d;
      gfill_q    <= gfill_d;
      tok_q      <= tok_d;
      flags_q    <= flags_d;
      iss_q      <= iss_d;
      rd_v_q     <= rd_v_d;
      ev_v_q     <= ev_v_d;
      fcnt_q     <= fcnt_d;
      fin_q      <= fin_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    lim_q      <= lim_d;
    dmax_q     <= dmax_d;
    raddr_q    <= raddr_d;
    dcnt_q     <= dcnt_d;
    best_q     <= best_d;
    bestd_q    <= bestd_d;
    out_byte_q <= out_byte_d;
    if (gb_we0) begin
      gbuf_q[gb_idx0] <= gb_dat0;
    end
    if (gb_we1) begin
      gbuf_q[gb_idx1] <= gb_dat1;
    end
  end

  assign in_i.ready     = (state_q == S_IDLE);
  assign out_o.valid    = out_v_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

  `LZSS_ASSERT(a_fill_bound, fill_q <= FW'(MAX_MATCH), "lookahead overfilled")
  `LZSS_ASSERT(a_tok_bound, (state_q == S_FLUSH) || (tok_q < TW'(GROUP_LEN)), "group held")
  `LZSS_ASSERT(a_best_lim, (state_q != S_EMIT) || (best_q <= lim_q), "match beyond limit")
  `LZSS_ASSERT_NEXT(a_final_reset, flush_load && fin_q && (fcnt_q == gfill_q), (state_q == S_IDLE) && (wh_q == '0), "stream end did not restart")

endmodule

FILE: sv/lzss_ram.sv
// ----------------------------------------------------------------------------
// LZSS generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4114
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lzss_cell.sv
// ----------------------------------------------------------------------------
// LZSS match cell
// Holds one window byte and one lookahead byte, passes both down the row,
// and extends the running match flag from its neighbour.
// ----------------------------------------------------------------------------
module lzss_cell import lzss_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [BYTE_W-1:0] hist_i,
  input  logic [BYTE_W-1:0] look_i,
  input  logic              live_i,
  input  logic              run_i,
  output logic [BYTE_W-1:0] hist_o,
  output logic [BYTE_W-1:0] look_o,
  output logic              run_o
);

  logic [BYTE_W-1:0] hist_q;
  logic [BYTE_W-1:0] look_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_hist) begin
      hist_q <= hist_i;
    end
    if (ctrl_i.shift_look) begin
      look_q <= look_i;
    end
  end

  // cells past the lookahead limit never count
  assign run_o  = run_i & live_i & (hist_q == look_q);
  assign hist_o = hist_q;
  assign look_o = look_q;

endmodule
